// ===== rtl/planar_raster_op_blitter_core_assert.svh =====
// Assertion macros shared by the blitter RTL.
`ifndef PLANAR_RASTER_OP_BLITTER_CORE_ASSERT_SVH
`define PLANAR_RASTER_OP_BLITTER_CORE_ASSERT_SVH

// Check a condition at every clock edge outside reset.
`define PROB_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that a condition implies another in the same cycle.
`define PROB_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Check that a condition implies another in the next cycle.
`define PROB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/prob_pkg.sv =====
// Types, constants and helper functions of the planar raster-op blitter.
`default_nettype none
package prob_pkg;

  localparam int STORE_BYTES_DEF = 524288;
  localparam int SHIFT_DEPTH_DEF = 64;

  localparam logic [19:0] WIN_LO   = 20'ha8000;
  localparam logic [19:0] WIN_HI   = 20'hb8000;
  localparam logic [19:0] WIN_MID  = 20'hb0000;
  localparam logic [18:0] PAGE_OFS = 19'h40000;

  localparam int ROP_CPU_BIT     = 8;
  localparam int ROP_DEC_BIT     = 9;
  localparam int ROP_EN_BIT      = 12;
  localparam int ROP_PATUP_BIT   = 13;
  localparam int ROP_PIXMODE_BIT = 15;

  typedef enum logic [3:0] {
    ACT_RD16     = 4'd0,
    ACT_RD32     = 4'd1,
    ACT_WR16     = 4'd2,
    ACT_WR32     = 4'd3,
    ACT_PAT_RD8  = 4'd4,
    ACT_PAT_WR8  = 4'd5,
    ACT_PAT_WR16 = 4'd6,
    ACT_PAT_WR32 = 4'd7,
    ACT_XFER_RST = 4'd8,
    ACT_STORE_WR = 4'd9,
    ACT_STORE_RD = 4'd10
  } act_t;

  typedef enum logic [3:0] {
    REG_ROP_CONTROL   = 4'd0,
    REG_PLANE_PROTECT = 4'd1,
    REG_PALETTE_ONE   = 4'd2,
    REG_PALETTE_TWO   = 4'd3,
    REG_PIXEL_MASK    = 4'd4,
    REG_SHIFT_AMOUNTS = 4'd5,
    REG_XFER_LENGTH   = 4'd6,
    REG_MODE_BITS     = 4'd7
  } reg_t;

  typedef enum logic [1:0] {
    METH_PATTERN = 2'd0,
    METH_PAL_TWO = 2'd1,
    METH_PAL_ONE = 2'd2,
    METH_PAL_BOTH = 2'd3
  } meth_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD_RUN,
    ST_WR_PUSH,
    ST_WR_CHECK,
    ST_WR_RD,
    ST_WR_WB,
    ST_STORE_RD,
    ST_STORE_CAP,
    ST_STORE_WR,
    ST_FINISH
  } state_t;

  typedef logic [7:0][31:0] pat_planes_t;

  // Gather one pixel color across the eight pattern planes.
  function automatic logic [7:0] pat_get(input pat_planes_t pl, input logic [4:0] px);
    logic [7:0] c;
    for (int p = 0; p < 8; p++) begin
      c[p] = pl[p][px];
    end
    return c;
  endfunction

  // Eight-term ternary raster operation.
  function automatic logic [7:0] ternary(input logic [7:0] code, input logic [7:0] s,
                                         input logic [7:0] d, input logic [7:0] p1,
                                         input logic [7:0] p2);
    logic [7:0] r;
    r = 8'h00;
    if (code[7]) r = r | (s & d & p1);
    if (code[6]) r = r | (s & d & ~p1);
    if (code[5]) r = r | (s & ~d & p1);
    if (code[4]) r = r | (s & ~d & ~p1);
    if (code[3]) r = r | (~s & d & p2);
    if (code[2]) r = r | (~s & d & ~p2);
    if (code[1]) r = r | (~s & ~d & p2);
    if (code[0]) r = r | (~s & ~d & ~p2);
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/prob_ram.sv =====
// Generic simple dual-port RAM with registered read data.
`default_nettype none
module prob_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Write one entry, read one entry a cycle.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule
`default_nettype wire

// ===== rtl/planar_raster_op_blitter_core.sv =====
// Top level of the planar raster-op blitter over an 8-bit-per-pixel store.
`default_nettype none
// After reset the block sweeps the pixel store to zero, one byte a cycle, and
// accepts no transaction until the sweep is done (configuration writes are
// taken meanwhile). One transaction is worked at a time by a sequencer around
// a single store with one read and one write port. A plane read of w pixels
// (16 or 32) reads them from the store one after another, and a plane read
// outside the window or in cpu-data mode goes straight to its last step. A
// plane write inside the window expands w-shift bits of CPU data into the
// shift buffer in cpu-data mode, checks the buffer fill, then steps through
// each pixel of the span written (w minus the destination shift, capped by the
// pixels left), with a store read and then a store write for each pixel
// enabled in the pixel write mask; if the buffer is short, it ends after the
// check. Writes outside the window, pattern accesses and transfer reset go
// straight to the last step; a raw store read adds a read and a capture step,
// and a raw store write one write step. The result waits in an output register,
// so the next transaction is accepted meanwhile; the block stalls in its last
// step only while that register still holds a result that has not been taken.
module planar_raster_op_blitter_core #(
  parameter int STORE_BYTES = prob_pkg::STORE_BYTES_DEF,
  parameter int SHIFT_DEPTH = prob_pkg::SHIFT_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // tdata: address[19:0], pattern_offset[27:20], write_data[59:28]
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [63:0] in_tdata,
  // tuser: action[3:0]
  input  wire logic [3:0]  in_tuser,
  // tdata: read_data[31:0], address_hit[32], write_skipped[33]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [39:0] out_tdata,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [3:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  localparam int SA = $clog2(STORE_BYTES);
  localparam int PW = $clog2(SHIFT_DEPTH);
  localparam int FW = $clog2(SHIFT_DEPTH + 1);
  localparam int MOD_STEPS = ((1 << 20) - 1) / STORE_BYTES;

  // Configuration registers.
  logic [15:0] rop_r;
  logic [7:0]  keep_r;
  logic [7:0]  pal1_r;
  logic [7:0]  pal2_r;
  logic [31:0] wmask_r;
  logic [15:0] shamt_r;
  logic [11:0] len_r;
  logic [2:0]  mode_r;

  prob_pkg::state_t state_r, state_nxt;

  logic [3:0]  act_r, act_nxt;
  logic [19:0] addr_r, addr_nxt;
  logic [31:0] wd_r, wd_nxt;
  logic [18:0] base_r, base_nxt;
  logic        w32_r, w32_nxt;
  logic [4:0]  sh_r, sh_nxt;
  logic [4:0]  dsh_r, dsh_nxt;
  logic [5:0]  idx_r, idx_nxt;
  logic [5:0]  n_r, n_nxt;
  logic [SA-1:0] a_r, a_nxt;
  logic [31:0] rd_r, rd_nxt;
  logic        hit_r, hit_nxt;
  logic        skip_r, skip_nxt;
  logic [12:0] rem_r, rem_nxt;
  logic        frp_r, frp_nxt;
  logic        fwp_r, fwp_nxt;
  logic        wide_r, wide_nxt;
  prob_pkg::pat_planes_t pat_r, pat_nxt;
  logic [FW-1:0] fill_r, fill_nxt;
  logic [PW-1:0] head_r, head_nxt;
  logic [SA-1:0] clr_r, clr_nxt;
  logic        out_valid_r;
  logic [39:0] out_data_r;

  // Input fields.
  logic [3:0]  in_act;
  logic [19:0] in_addr;
  logic [7:0]  in_off;
  logic [31:0] in_wd;
  assign in_act  = in_tuser;
  assign in_addr = in_tdata[19:0];
  assign in_off  = in_tdata[27:20];
  assign in_wd   = in_tdata[59:28];

  logic cpu_mode, dec_mode, patup, rop_en, pixmode;
  assign cpu_mode = rop_r[prob_pkg::ROP_CPU_BIT];
  assign dec_mode = rop_r[prob_pkg::ROP_DEC_BIT];
  assign rop_en   = rop_r[prob_pkg::ROP_EN_BIT];
  assign patup    = rop_r[prob_pkg::ROP_PATUP_BIT];
  assign pixmode  = rop_r[prob_pkg::ROP_PIXMODE_BIT];

  // Window decode of the CPU address.
  logic        win_hit;
  logic [19:0] win_rel;
  logic [18:0] win_base;
  assign win_hit = (in_addr >= prob_pkg::WIN_LO) && (in_addr < prob_pkg::WIN_HI) &&
                   (mode_r[1] || (in_addr < prob_pkg::WIN_MID));
  assign win_rel = in_addr - prob_pkg::WIN_LO;
  assign win_base = {win_rel[15:0], 3'b000} +
                    ((!mode_r[1] && mode_r[2]) ? prob_pkg::PAGE_OFS : 19'd0);

  // Transfer start as seen by a plane access.
  logic          bt;
  logic [12:0]   rem_b;
  logic          frp_b, fwp_b;
  logic [4:0]    wm1;
  assign bt    = (rem_r == 13'd0);
  assign rem_b = bt ? (13'(len_r) + 13'd1) : rem_r;
  assign frp_b = bt ? 1'b1 : frp_r;
  assign fwp_b = bt ? 1'b1 : fwp_r;
  assign wm1   = in_act[0] ? 5'd31 : 5'd15;

  logic [5:0] wlen;
  assign wlen = w32_r ? 6'd32 : 6'd16;

  // Wrapping add on shift-buffer pointers.
  function automatic logic [PW-1:0] ptr_add(input logic [PW-1:0] p, input logic [PW:0] k);
    logic [PW+1:0] s;
    s = {2'b00, p} + {1'b0, k};
    if (s >= (PW+2)'(SHIFT_DEPTH)) s = s - (PW+2)'(SHIFT_DEPTH);
    return s[PW-1:0];
  endfunction

  // Pixel address of the current step.
  logic [5:0]  pk;
  logic [18:0] pix;
  always_comb begin
    pk = (state_r == prob_pkg::ST_WR_RD) ? (6'(dsh_r) + idx_r) : idx_r;
    if (dec_mode) begin
      pix = base_r + 19'(wlen) - 19'd1 - 19'(pk);
    end else begin
      pix = base_r + 19'(pk);
    end
  end

  // Reduce a store index modulo the store size.
  logic [19:0]   mod_x, mod_y;
  logic [SA-1:0] mod_out;
  always_comb begin
    if ((state_r == prob_pkg::ST_STORE_RD) || (state_r == prob_pkg::ST_STORE_WR)) begin
      mod_x = addr_r;
    end else begin
      mod_x = {1'b0, pix};
    end
    mod_y = mod_x;
    for (int k = 1; k <= MOD_STEPS; k++) begin
      if ({1'b0, mod_x} >= 21'(k * STORE_BYTES)) begin
        mod_y = 20'({1'b0, mod_x} - 21'(k * STORE_BYTES));
      end
    end
  end
  assign mod_out = mod_y[SA-1:0];

  // Memories.
  logic          st_we;
  logic [SA-1:0] st_waddr;
  logic [7:0]    st_wdata;
  logic [7:0]    st_rdata;
  logic          bf_we;
  logic [PW-1:0] bf_waddr;
  logic [7:0]    bf_wdata;
  logic [PW-1:0] bf_raddr;
  logic [7:0]    bf_rdata;

  prob_ram #(.WIDTH(8), .DEPTH(STORE_BYTES)) u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .raddr (mod_out),
    .rdata (st_rdata)
  );

  prob_ram #(.WIDTH(8), .DEPTH(SHIFT_DEPTH)) u_shift (
    .clk   (clk),
    .we    (bf_we),
    .waddr (bf_waddr),
    .wdata (bf_wdata),
    .raddr (bf_raddr),
    .rdata (bf_rdata)
  );

  // Derived values for the write loop.
  logic [5:0] wr_span, nn;
  logic [4:0] wr_bit;
  logic       wr_en_px;
  logic [4:0] push_bit;
  logic [4:0] rd_j;
  logic [4:0] pat_px;
  assign wr_span  = wlen - 6'(dsh_r);
  assign nn       = (13'(wr_span) > rem_r) ? rem_r[5:0] : wr_span;
  assign wr_bit   = 5'(6'(dsh_r) + idx_r) ^ 5'd7;
  assign wr_en_px = wmask_r[wr_bit];
  assign push_bit = 5'(idx_r + 6'(sh_r)) ^ 5'd7;
  assign rd_j     = 5'(idx_r - 6'd1);
  assign pat_px   = {a_r[4] & wide_r, a_r[3:0]};

  // Raster result for the pixel in the write-back step.
  logic [7:0] p1, p2, rop_res, wb_data;
  always_comb begin
    case (prob_pkg::meth_t'(rop_r[11:10]))
      prob_pkg::METH_PATTERN: begin
        p1 = prob_pkg::pat_get(pat_r, pat_px);
        p2 = p1;
      end
      prob_pkg::METH_PAL_TWO: begin
        p1 = pal2_r;
        p2 = pal2_r;
      end
      prob_pkg::METH_PAL_ONE: begin
        p1 = pal1_r;
        p2 = pal1_r;
      end
      default: begin
        p1 = pal1_r;
        p2 = pal2_r;
      end
    endcase
    rop_res = rop_en ? prob_pkg::ternary(rop_r[7:0], bf_rdata, st_rdata, p1, p2) : bf_rdata;
    wb_data = (st_rdata & keep_r) | (rop_res & ~keep_r);
  end

  // Push into the shift buffer.
  logic       push_en;
  logic [7:0] push_data;
  always_comb begin
    push_en   = 1'b0;
    push_data = st_rdata;
    case (state_r)
      prob_pkg::ST_RD_RUN: begin
        push_en = (idx_r != 6'd0) && (rd_j >= sh_r);
      end
      prob_pkg::ST_WR_PUSH: begin
        push_en   = 1'b1;
        push_data = wd_r[push_bit] ? 8'hff : 8'h00;
      end
      default: ;
    endcase
  end
  assign bf_we    = push_en;
  assign bf_wdata = push_data;
  assign bf_waddr = (fill_r == FW'(SHIFT_DEPTH)) ? head_r :
                    ptr_add(head_r, (PW+1)'(fill_r));
  assign bf_raddr = ptr_add(head_r, (PW+1)'(idx_r));

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      prob_pkg::ST_CLEAR: begin
        if (clr_r == SA'(STORE_BYTES - 1)) state_nxt = prob_pkg::ST_IDLE;
      end
      prob_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          case (in_act)
            prob_pkg::ACT_RD16, prob_pkg::ACT_RD32: begin
              state_nxt = (win_hit && !cpu_mode) ? prob_pkg::ST_RD_RUN : prob_pkg::ST_FINISH;
            end
            prob_pkg::ACT_WR16, prob_pkg::ACT_WR32: begin
              if (!win_hit) state_nxt = prob_pkg::ST_FINISH;
              else if (cpu_mode) state_nxt = prob_pkg::ST_WR_PUSH;
              else state_nxt = prob_pkg::ST_WR_CHECK;
            end
            prob_pkg::ACT_STORE_WR: state_nxt = prob_pkg::ST_STORE_WR;
            prob_pkg::ACT_STORE_RD: state_nxt = prob_pkg::ST_STORE_RD;
            default: state_nxt = prob_pkg::ST_FINISH;
          endcase
        end
      end
      prob_pkg::ST_RD_RUN: begin
        if (idx_r == wlen) state_nxt = prob_pkg::ST_FINISH;
      end
      prob_pkg::ST_WR_PUSH: begin
        if (idx_r == (wlen - 6'(sh_r) - 6'd1)) state_nxt = prob_pkg::ST_WR_CHECK;
      end
      prob_pkg::ST_WR_CHECK: begin
        state_nxt = (fill_r < FW'(nn)) ? prob_pkg::ST_FINISH : prob_pkg::ST_WR_RD;
      end
      prob_pkg::ST_WR_RD: begin
        if (idx_r == n_r) state_nxt = prob_pkg::ST_FINISH;
        else if (wr_en_px) state_nxt = prob_pkg::ST_WR_WB;
      end
      prob_pkg::ST_WR_WB:     state_nxt = prob_pkg::ST_WR_RD;
      prob_pkg::ST_STORE_RD:  state_nxt = prob_pkg::ST_STORE_CAP;
      prob_pkg::ST_STORE_CAP: state_nxt = prob_pkg::ST_FINISH;
      prob_pkg::ST_STORE_WR:  state_nxt = prob_pkg::ST_FINISH;
      prob_pkg::ST_FINISH: begin
        if (!out_valid_r || out_tready) state_nxt = prob_pkg::ST_IDLE;
      end
      default: state_nxt = prob_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_tready = (state_r == prob_pkg::ST_IDLE);
    st_we     = 1'b0;
    st_waddr  = a_r;
    st_wdata  = wb_data;
    case (state_r)
      prob_pkg::ST_CLEAR: begin
        st_we    = 1'b1;
        st_waddr = clr_r;
        st_wdata = 8'h00;
      end
      prob_pkg::ST_STORE_WR: begin
        st_we    = 1'b1;
        st_waddr = mod_out;
        st_wdata = wd_r[7:0];
      end
      prob_pkg::ST_WR_WB: begin
        st_we = 1'b1;
      end
      default: ;
    endcase
  end

  // Datapath next values.
  always_comb begin
    logic [5:0]  pidx;
    logic [1:0]  pbp;
    logic [12:0] rem_new;
    pidx = in_off[7:2];
    pbp  = in_off[1:0];
    rem_new = rem_r - 13'(n_r);
    act_nxt  = act_r;
    addr_nxt = addr_r;
    wd_nxt   = wd_r;
    base_nxt = base_r;
    w32_nxt  = w32_r;
    sh_nxt   = sh_r;
    dsh_nxt  = dsh_r;
    idx_nxt  = idx_r;
    n_nxt    = n_r;
    a_nxt    = a_r;
    rd_nxt   = rd_r;
    hit_nxt  = hit_r;
    skip_nxt = skip_r;
    rem_nxt  = rem_r;
    frp_nxt  = frp_r;
    fwp_nxt  = fwp_r;
    wide_nxt = wide_r;
    pat_nxt  = pat_r;
    fill_nxt = fill_r;
    head_nxt = head_r;
    clr_nxt  = clr_r;
    case (state_r)
      prob_pkg::ST_CLEAR: begin
        clr_nxt = clr_r + SA'(1);
      end
      prob_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          act_nxt  = in_act;
          addr_nxt = in_addr;
          wd_nxt   = in_act[0] ? in_wd : {16'h0000, in_wd[15:0]};
          base_nxt = win_base;
          w32_nxt  = in_act[0];
          rd_nxt   = 32'd0;
          hit_nxt  = 1'b0;
          skip_nxt = 1'b0;
          idx_nxt  = 6'd0;
          case (in_act)
            prob_pkg::ACT_RD16, prob_pkg::ACT_RD32: begin
              if (win_hit) begin
                hit_nxt = 1'b1;
                if (!cpu_mode) begin
                  rem_nxt = rem_b;
                  fwp_nxt = fwp_b;
                  if (bt) begin
                    fill_nxt = '0;
                    head_nxt = '0;
                  end
                  sh_nxt  = frp_b ? (shamt_r[4:0] & wm1) : 5'd0;
                  frp_nxt = 1'b0;
                  if (patup) wide_nxt = in_act[0];
                end
              end
            end
            prob_pkg::ACT_WR16, prob_pkg::ACT_WR32: begin
              if (win_hit) begin
                hit_nxt = 1'b1;
                rem_nxt = rem_b;
                frp_nxt = frp_b;
                fwp_nxt = fwp_b;
                if (bt) begin
                  fill_nxt = '0;
                  head_nxt = '0;
                end
                dsh_nxt = fwp_b ? (shamt_r[12:8] & wm1) : 5'd0;
                if (cpu_mode) begin
                  sh_nxt  = frp_b ? (shamt_r[4:0] & wm1) : 5'd0;
                  frp_nxt = 1'b0;
                end
              end
            end
            prob_pkg::ACT_PAT_RD8: begin
              if (pixmode) begin
                if ((pbp == 2'd0) && (pidx <= 6'd31)) begin
                  rd_nxt = {24'h0, prob_pkg::pat_get(pat_r, pidx[4:0])};
                end
              end else if ((pidx < 6'd8) && (wide_r || (pbp < 2'd2))) begin
                rd_nxt = {24'h0, pat_r[pidx[2:0]][{pbp, 3'b000} +: 8]};
              end
            end
            prob_pkg::ACT_PAT_WR8, prob_pkg::ACT_PAT_WR16, prob_pkg::ACT_PAT_WR32: begin
              if (pixmode) begin
                if ((pbp == 2'd0) && (pidx <= 6'd31)) begin
                  for (int p = 0; p < 8; p++) pat_nxt[p][pidx[4:0]] = in_wd[p];
                end
              end else if (pidx < 6'd8) begin
                if (in_act == prob_pkg::ACT_PAT_WR8) begin
                  if (pbp >= 2'd2) wide_nxt = 1'b1;
                  pat_nxt[pidx[2:0]][{pbp, 3'b000} +: 8] = in_wd[7:0];
                end else if (pbp == 2'd0) begin
                  if (in_act == prob_pkg::ACT_PAT_WR16) begin
                    wide_nxt = 1'b0;
                    pat_nxt[pidx[2:0]][15:0] = in_wd[15:0];
                  end else begin
                    wide_nxt = 1'b1;
                    pat_nxt[pidx[2:0]] = in_wd;
                  end
                end
              end
            end
            prob_pkg::ACT_XFER_RST: begin
              rem_nxt  = 13'd0;
              frp_nxt  = 1'b0;
              fwp_nxt  = 1'b0;
              fill_nxt = '0;
            end
            default: ;
          endcase
        end
      end
      prob_pkg::ST_RD_RUN: begin
        // Issue the next store read, then handle the pixel that came back.
        if (idx_r != wlen) begin
          idx_nxt = idx_r + 6'd1;
          a_nxt   = mod_out;
        end
        if (idx_r != 6'd0) begin
          if (mode_r[0] && (((st_rdata ^ pal1_r) & ~keep_r) == 8'h00)) begin
            rd_nxt[rd_j] = 1'b1;
          end
          if (patup) begin
            for (int p = 0; p < 8; p++) pat_nxt[p][pat_px] = st_rdata[p];
          end
        end
      end
      prob_pkg::ST_WR_PUSH: begin
        if (idx_r == (wlen - 6'(sh_r) - 6'd1)) idx_nxt = 6'd0;
        else idx_nxt = idx_r + 6'd1;
      end
      prob_pkg::ST_WR_CHECK: begin
        if (fill_r < FW'(nn)) begin
          skip_nxt = 1'b1;
        end else begin
          n_nxt   = nn;
          idx_nxt = 6'd0;
        end
      end
      prob_pkg::ST_WR_RD: begin
        if (idx_r == n_r) begin
          // Drop the used pixels and advance the length counter.
          if (FW'(n_r) >= fill_r) begin
            fill_nxt = '0;
          end else begin
            head_nxt = ptr_add(head_r, (PW+1)'(n_r));
            fill_nxt = fill_r - FW'(n_r);
          end
          fwp_nxt = 1'b0;
          if (rem_new == 13'd0) begin
            rem_nxt  = 13'd0;
            frp_nxt  = 1'b0;
            fill_nxt = '0;
          end else begin
            rem_nxt = rem_new;
          end
        end else if (wr_en_px) begin
          a_nxt = mod_out;
        end else begin
          idx_nxt = idx_r + 6'd1;
        end
      end
      prob_pkg::ST_WR_WB: begin
        idx_nxt = idx_r + 6'd1;
      end
      prob_pkg::ST_STORE_CAP: begin
        rd_nxt = {24'h0, st_rdata};
      end
      default: ;
    endcase
    // Advance fill or drop the oldest pixel on a push.
    if (push_en) begin
      if (fill_r == FW'(SHIFT_DEPTH)) head_nxt = ptr_add(head_r, (PW+1)'(1));
      else fill_nxt = fill_r + FW'(1);
    end
  end

  // Control and state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= prob_pkg::ST_CLEAR;
      clr_r       <= '0;
      rem_r       <= 13'd0;
      frp_r       <= 1'b0;
      fwp_r       <= 1'b0;
      wide_r      <= 1'b0;
      pat_r       <= '0;
      fill_r      <= '0;
      head_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      rem_r   <= rem_nxt;
      frp_r   <= frp_nxt;
      fwp_r   <= fwp_nxt;
      wide_r  <= wide_nxt;
      pat_r   <= pat_nxt;
      fill_r  <= fill_nxt;
      head_r  <= head_nxt;
      if ((state_r == prob_pkg::ST_FINISH) && (!out_valid_r || out_tready)) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    act_r  <= act_nxt;
    addr_r <= addr_nxt;
    wd_r   <= wd_nxt;
    base_r <= base_nxt;
    w32_r  <= w32_nxt;
    sh_r   <= sh_nxt;
    dsh_r  <= dsh_nxt;
    idx_r  <= idx_nxt;
    n_r    <= n_nxt;
    a_r    <= a_nxt;
    rd_r   <= rd_nxt;
    hit_r  <= hit_nxt;
    skip_r <= skip_nxt;
    if ((state_r == prob_pkg::ST_FINISH) && (!out_valid_r || out_tready)) begin
      out_data_r <= {6'd0, skip_r, hit_r, rd_r};
    end
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rop_r   <= 16'd0;
      keep_r  <= 8'd0;
      pal1_r  <= 8'd0;
      pal2_r  <= 8'd0;
      wmask_r <= 32'd0;
      shamt_r <= 16'd0;
      len_r   <= 12'd0;
      mode_r  <= 3'd0;
    end else if (cfg_valid) begin
      case (cfg_index)
        prob_pkg::REG_ROP_CONTROL:   rop_r   <= cfg_data[15:0];
        prob_pkg::REG_PLANE_PROTECT: keep_r  <= cfg_data[7:0];
        prob_pkg::REG_PALETTE_ONE:   pal1_r  <= cfg_data[7:0];
        prob_pkg::REG_PALETTE_TWO:   pal2_r  <= cfg_data[7:0];
        prob_pkg::REG_PIXEL_MASK:    wmask_r <= cfg_data;
        prob_pkg::REG_SHIFT_AMOUNTS: shamt_r <= cfg_data[15:0];
        prob_pkg::REG_XFER_LENGTH:   len_r   <= cfg_data[11:0];
        prob_pkg::REG_MODE_BITS:     mode_r  <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // act_r records the transaction kind, which the raw-store assertion checks.
  logic act_raw;
  assign act_raw = (act_r == prob_pkg::ACT_STORE_WR) || (act_r == prob_pkg::ACT_STORE_RD);

`include "planar_raster_op_blitter_core_assert.svh"

  `PROB_ASSERT_ALWAYS(a_fill_bound, fill_r <= FW'(SHIFT_DEPTH), "shift fill above depth")
  `PROB_ASSERT_IMPLY(a_idle_xfer, rem_r == 13'd0, !frp_r && !fwp_r, "first flags without transfer")
  `PROB_ASSERT_NEXT(a_short_skip, (state_r == prob_pkg::ST_WR_CHECK) && (fill_r < FW'(nn)), (state_r == prob_pkg::ST_FINISH) && skip_r, "short buffer not skipped")
  `PROB_ASSERT_IMPLY(a_raw_state, (state_r == prob_pkg::ST_STORE_RD) || (state_r == prob_pkg::ST_STORE_WR), act_raw, "raw store step for plane action")

endmodule
`default_nettype wire
